// ----- hdl/ota_ladder_filter_rk4_core_macros.svh -----
// assertion helpers used by olfrk4_ctrl
// each macro expects clk and rst_n in scope
`ifndef OTA_LADDER_FILTER_RK4_CORE_MACROS_SVH
`define OTA_LADDER_FILTER_RK4_CORE_MACROS_SVH

// same-cycle implication
`define OLFRK4_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OLFRK4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/olfrk4_pkg.sv -----
`timescale 1ns / 1ps
package olfrk4_pkg;

    // field and state widths
    localparam int OS_W     = 4;
    localparam int SR_W     = 18;
    localparam int CFG_W    = 18;
    localparam int CIDX_W   = 2;
    localparam int STAGES   = 4;
    localparam int MAX_OVERSAMPLE = 8;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_OVERSAMPLE  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_SAMPLE_RATE = 2'd1;

    // iteration counts of the shared units
    localparam int KDIV_CYCLES = 43;
    localparam int DIV6_CYCLES = 11;
    localparam int CNT_W       = 6;

    // fixed-point constants
    localparam logic [26:0]        TWO_PI_Q24 = 27'd105414268;
    localparam logic signed [17:0] C_1P1_Q16  = 18'sd72090;
    localparam logic signed [17:0] C_1P96_Q16 = 18'sd128451;
    localparam logic [63:0]        EXP_QUARTER_Q30 = 64'd1378711793;

    // datapath operations
    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_PREP   = 4'd2;
    localparam logic [3:0] OP_KDIV   = 4'd3;
    localparam logic [3:0] OP_KSAT   = 4'd4;
    localparam logic [3:0] OP_SINIT  = 4'd5;
    localparam logic [3:0] OP_FBMUL  = 4'd6;
    localparam logic [3:0] OP_TANH   = 4'd7;
    localparam logic [3:0] OP_RESMUL = 4'd8;
    localparam logic [3:0] OP_UMUL   = 4'd9;
    localparam logic [3:0] OP_DHMUL  = 4'd10;
    localparam logic [3:0] OP_UPD    = 4'd11;
    localparam logic [3:0] OP_D6LOAD = 4'd12;
    localparam logic [3:0] OP_D6     = 4'd13;
    localparam logic [3:0] OP_COMMIT = 4'd14;
    localparam logic [3:0] OP_OUT    = 4'd15;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] stage;
        logic [1:0] eval;
    } dp_cmd_t;

    typedef struct packed {
        logic [OS_W-1:0] os_count;
    } dp_stat_t;

    // tanh table, q16, tanh(j/8) for j = 0..32
    typedef logic [16:0] tanh_rom_t [0:32];

    function automatic tanh_rom_t build_tanh_rom();
        tanh_rom_t   rom;
        logic [63:0] one;
        logic [63:0] p;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] q;
        one = 64'd1 << 20;
        p   = one;
        for (int j = 0; j <= 32; j++) begin
            den = p + one;
            num = ((p - one) << 16) + (den >> 1);
            q   = 64'd0;
            // shift-subtract quotient
            for (int b = 16; b >= 0; b--) begin
                if (num >= (den << b)) begin
                    num = num - (den << b);
                    q   = q | (64'd1 << b);
                end
            end
            rom[j] = q[16:0];
            if (j < 32) begin
                p = (p * EXP_QUARTER_Q30 + (64'd1 << 29)) >> 30;
            end
        end
        return rom;
    endfunction

    localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

// ----- hdl/olfrk4_ctrl.sv -----
`timescale 1ns / 1ps
`include "ota_ladder_filter_rk4_core_macros.svh"
module olfrk4_ctrl
    import olfrk4_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_KDIV   = 4'd2;
    localparam logic [3:0] S_KSAT   = 4'd3;
    localparam logic [3:0] S_SINIT  = 4'd4;
    localparam logic [3:0] S_FBMUL  = 4'd5;
    localparam logic [3:0] S_FBTANH = 4'd6;
    localparam logic [3:0] S_RESMUL = 4'd7;
    localparam logic [3:0] S_UMUL   = 4'd8;
    localparam logic [3:0] S_UTANH  = 4'd9;
    localparam logic [3:0] S_DHMUL  = 4'd10;
    localparam logic [3:0] S_UPD    = 4'd11;
    localparam logic [3:0] S_D6LOAD = 4'd12;
    localparam logic [3:0] S_D6     = 4'd13;
    localparam logic [3:0] S_COMMIT = 4'd14;
    localparam logic [3:0] S_OUT    = 4'd15;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       stage_reg, stage_next;
    logic [1:0]       eval_reg, eval_next;
    logic [OS_W-1:0]  step_reg, step_next;
    logic             out_valid_reg, out_valid_next;

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        stage_next = stage_reg;
        eval_next  = eval_reg;
        step_next  = step_reg;
        cmd.op     = OP_NOP;
        cmd.stage  = stage_reg;
        cmd.eval   = eval_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    step_next  = '0;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.op     = OP_PREP;
                cnt_next   = '0;
                state_next = S_KDIV;
            end
            S_KDIV:
            begin
                cmd.op = OP_KDIV;
                if (cnt_reg == CNT_W'(KDIV_CYCLES - 1))
                    state_next = S_KSAT;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_KSAT:
            begin
                cmd.op     = OP_KSAT;
                step_next  = '0;
                state_next = S_SINIT;
            end
            S_SINIT:
            begin
                cmd.op     = OP_SINIT;
                stage_next = 2'd0;
                eval_next  = 2'd0;
                state_next = S_FBMUL;
            end
            S_FBMUL:
            begin
                cmd.op     = OP_FBMUL;
                state_next = S_FBTANH;
            end
            S_FBTANH:
            begin
                cmd.op     = OP_TANH;
                state_next = S_RESMUL;
            end
            S_RESMUL:
            begin
                cmd.op     = OP_RESMUL;
                state_next = S_UMUL;
            end
            S_UMUL:
            begin
                cmd.op     = OP_UMUL;
                state_next = S_UTANH;
            end
            S_UTANH:
            begin
                cmd.op     = OP_TANH;
                state_next = S_DHMUL;
            end
            S_DHMUL:
            begin
                cmd.op = OP_DHMUL;
                if (stage_reg == 2'd3)
                    state_next = S_UPD;
                else
                begin
                    stage_next = stage_reg + 2'd1;
                    state_next = S_UMUL;
                end
            end
            S_UPD:
            begin
                cmd.op = OP_UPD;
                if (eval_reg == 2'd3)
                    state_next = S_D6LOAD;
                else
                begin
                    eval_next  = eval_reg + 2'd1;
                    stage_next = 2'd0;
                    state_next = S_FBMUL;
                end
            end
            S_D6LOAD:
            begin
                cmd.op     = OP_D6LOAD;
                cnt_next   = '0;
                state_next = S_D6;
            end
            S_D6:
            begin
                cmd.op = OP_D6;
                if (cnt_reg == CNT_W'(DIV6_CYCLES - 1))
                    state_next = S_COMMIT;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_COMMIT:
            begin
                cmd.op = OP_COMMIT;
                if (step_reg == stat.os_count - 1'b1)
                    state_next = S_OUT;
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = S_SINIT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output beat valid
    always_comb
    begin
        if (cmd.op == OP_OUT)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            stage_reg     <= 2'd0;
            eval_reg      <= 2'd0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            stage_reg     <= stage_next;
            eval_reg      <= eval_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `OLFRK4_ASSERT_SAME(a_kdiv_cnt, state_reg == S_KDIV, cnt_reg < CNT_W'(KDIV_CYCLES), "kh divider overran")
    `OLFRK4_ASSERT_SAME(a_out_free, cmd.op == OP_OUT, !out_valid_reg || out_ready, "result beat overwritten")
    `OLFRK4_ASSERT_SAME(a_step_range, state_reg != S_IDLE, step_reg < stat.os_count, "step count out of range")
    `OLFRK4_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")

endmodule

// ----- hdl/olfrk4_dp.sv -----
`timescale 1ns / 1ps
module olfrk4_dp
    import olfrk4_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic signed [23:0]  audio_in,
    input  logic [15:0]         cutoff_hz,
    input  logic signed [15:0]  resonance,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    output logic signed [23:0]  filter_out
);

    // configuration
    logic [OS_W-1:0] os_reg;
    logic [SR_W-1:0] sr_reg;
    logic [OS_W-1:0] os_c;
    logic [SR_W-1:0] sr_c;

    // per-item operands
    logic signed [26:0] in_reg, in_next;
    logic [14:0]        res_reg, res_next;
    logic [15:0]        cut_reg, cut_next;
    logic [42:0]        num_reg, num_next;
    logic [21:0]        div_reg, div_next;
    logic [21:0]        rem_reg, rem_next;
    logic [28:0]        kh_reg, kh_next;

    // integration state and scratch
    logic signed [31:0] s_reg [STAGES];
    logic signed [31:0] s_next [STAGES];
    logic signed [31:0] t_reg [STAGES];
    logic signed [31:0] t_next [STAGES];
    logic signed [41:0] d_reg [STAGES];
    logic signed [41:0] d_next [STAGES];
    logic signed [44:0] acc_reg [STAGES];
    logic signed [44:0] acc_next [STAGES];
    logic [43:0]        work_reg [STAGES];
    logic [43:0]        work_next [STAGES];
    logic [1:0]         rem3_reg [STAGES];
    logic [1:0]         rem3_next [STAGES];
    logic               neg_reg [STAGES];
    logic               neg_next [STAGES];
    logic signed [33:0] arg_reg, arg_next;
    logic signed [27:0] th_reg, th_next;
    logic signed [31:0] r_reg, r_next;
    logic signed [23:0] out_reg, out_next;

    // combinational intermediates
    logic [22:0]        kd_trial;
    logic signed [49:0] fb_prod, fb_adj;
    logic signed [31:0] u_prev;
    logic [1:0]         stage_m1;
    logic signed [49:0] u_prod, u_adj;
    logic signed [33:0] u_val;
    logic signed [43:0] rs_prod, rs_adj;
    logic signed [57:0] dh_prod, dh_adj;
    logic               th_neg;
    logic [33:0]        th_mag;
    logic [5:0]         th_lo_idx, th_hi_idx;
    logic [16:0]        th_lo, th_hi, th_diff, th_y;
    logic [39:0]        th_interp;
    logic signed [27:0] th_abs;
    logic signed [41:0] dh_half [STAGES];
    logic signed [41:0] dh_add [STAGES];
    logic signed [44:0] acc_mag [STAGES];
    logic [5:0]         d6_v [STAGES];
    logic [11:0]        d6_p [STAGES];
    logic [3:0]         d6_q [STAGES];
    logic signed [44:0] d6_sq [STAGES];
    logic signed [32:0] y_adj;
    logic signed [29:0] y_div;

    function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
        if (v > 46'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -46'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            os_reg <= OS_W'(2);
            sr_reg <= SR_W'(44100);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_OVERSAMPLE:  os_reg <= cfg_data[OS_W-1:0];
                REG_SAMPLE_RATE: sr_reg <= cfg_data[SR_W-1:0];
                default:         ;
            endcase
        end
    end

    // clamped settings
    always_comb
    begin
        if (os_reg == '0)
            os_c = OS_W'(1);
        else if (os_reg > OS_W'(MAX_OVERSAMPLE))
            os_c = OS_W'(MAX_OVERSAMPLE);
        else
            os_c = os_reg;
        sr_c = (sr_reg == '0) ? SR_W'(1) : sr_reg;
    end

    assign stat.os_count = os_c;

    // shared arithmetic
    always_comb
    begin
        kd_trial = {rem_reg, num_reg[42]};

        fb_prod = t_reg[3] * C_1P96_Q16;
        fb_adj  = fb_prod + (fb_prod[49] ? 50'sd65535 : 50'sd0);

        stage_m1 = cmd.stage - 2'd1;
        u_prev   = (cmd.stage == 2'd0) ? 32'(in_reg) : t_reg[stage_m1];
        u_prod   = u_prev * C_1P1_Q16;
        u_adj    = u_prod + (u_prod[49] ? 50'sd65535 : 50'sd0);
        u_val    = u_adj[49:16] - ((cmd.stage == 2'd0) ? 34'(r_reg) : 34'sd0)
                   - 34'(t_reg[cmd.stage]);

        rs_prod = $signed({1'b0, res_reg}) * th_reg;
        rs_adj  = rs_prod + (rs_prod[43] ? 44'sd4095 : 44'sd0);

        dh_prod = $signed({1'b0, kh_reg}) * th_reg;
        dh_adj  = dh_prod + (dh_prod[57] ? 58'sd16383 : 58'sd0);

        // interpolated tanh of arg_reg, q26 result
        th_neg    = arg_reg[33];
        th_mag    = th_neg ? 34'(-arg_reg) : 34'(arg_reg);
        th_lo_idx = {1'b0, th_mag[27:23]};
        th_hi_idx = th_lo_idx + 6'd1;
        th_lo     = TANH_ROM[th_lo_idx];
        th_hi     = TANH_ROM[th_hi_idx];
        th_diff   = th_hi - th_lo;
        th_interp = th_diff * th_mag[22:0];
        th_y      = (|th_mag[33:28]) ? TANH_ROM[32] : th_lo + th_interp[39:23];
        th_abs    = $signed({1'b0, th_y, 10'b0});

        // per-lane updates
        for (int i = 0; i < STAGES; i++)
        begin
            dh_half[i] = (d_reg[i] + (d_reg[i][41] ? 42'sd1 : 42'sd0)) >>> 1;
            dh_add[i]  = (cmd.eval == 2'd2) ? d_reg[i] : dh_half[i];
            acc_mag[i] = acc_reg[i][44] ? -acc_reg[i] : acc_reg[i];
            d6_v[i]    = {rem3_reg[i], work_reg[i][43:40]};
            d6_p[i]    = 12'(d6_v[i]) * 12'd43;
            d6_q[i]    = d6_p[i][10:7];
            d6_sq[i]   = neg_reg[i] ? -$signed({1'b0, work_reg[i]})
                                    : $signed({1'b0, work_reg[i]});
        end

        y_adj = 33'(s_reg[3]) + (s_reg[3][31] ? 33'sd7 : 33'sd0);
        y_div = y_adj[32:3];
    end

    // next-state selection
    always_comb
    begin
        in_next  = in_reg;
        res_next = res_reg;
        cut_next = cut_reg;
        num_next = num_reg;
        div_next = div_reg;
        rem_next = rem_reg;
        kh_next  = kh_reg;
        arg_next = arg_reg;
        th_next  = th_reg;
        r_next   = r_reg;
        out_next = out_reg;
        for (int i = 0; i < STAGES; i++)
        begin
            s_next[i]    = s_reg[i];
            t_next[i]    = t_reg[i];
            d_next[i]    = d_reg[i];
            acc_next[i]  = acc_reg[i];
            work_next[i] = work_reg[i];
            rem3_next[i] = rem3_reg[i];
            neg_next[i]  = neg_reg[i];
        end
        case (cmd.op)
            OP_LOAD:
            begin
                in_next  = {audio_in, 3'b000};
                res_next = resonance[15] ? 15'd0 : resonance[14:0];
                cut_next = cutoff_hz;
            end
            OP_PREP:
            begin
                num_next = 43'(cut_reg) * 43'(TWO_PI_Q24);
                div_next = 22'(os_c) * 22'(sr_c);
                rem_next = '0;
            end
            OP_KDIV:
            begin
                if (kd_trial >= {1'b0, div_reg})
                begin
                    rem_next = 22'(kd_trial - {1'b0, div_reg});
                    num_next = {num_reg[41:0], 1'b1};
                end
                else
                begin
                    rem_next = kd_trial[21:0];
                    num_next = {num_reg[41:0], 1'b0};
                end
            end
            OP_KSAT:
            begin
                kh_next = (num_reg > 43'd268435456) ? 29'd268435456 : num_reg[28:0];
            end
            OP_SINIT:
            begin
                for (int i = 0; i < STAGES; i++)
                begin
                    t_next[i]   = s_reg[i];
                    acc_next[i] = '0;
                end
            end
            OP_FBMUL:  arg_next = fb_adj[49:16];
            OP_TANH:   th_next  = th_neg ? -th_abs : th_abs;
            OP_RESMUL: r_next   = rs_adj[43:12];
            OP_UMUL:   arg_next = u_val;
            OP_DHMUL:  d_next[cmd.stage] = dh_adj[55:14];
            OP_UPD:
            begin
                for (int i = 0; i < STAGES; i++)
                begin
                    t_next[i] = sat32(46'(s_reg[i]) + 46'(dh_add[i]));
                    if (cmd.eval == 2'd1 || cmd.eval == 2'd2)
                        acc_next[i] = acc_reg[i] + (45'(d_reg[i]) <<< 1);
                    else
                        acc_next[i] = acc_reg[i] + 45'(d_reg[i]);
                end
            end
            OP_D6LOAD:
            begin
                for (int i = 0; i < STAGES; i++)
                begin
                    work_next[i] = acc_mag[i][44:1];
                    neg_next[i]  = acc_reg[i][44];
                    rem3_next[i] = 2'd0;
                end
            end
            OP_D6:
            begin
                // one quotient nibble per lane
                for (int i = 0; i < STAGES; i++)
                begin
                    work_next[i] = {work_reg[i][39:0], d6_q[i]};
                    rem3_next[i] = 2'(d6_v[i] - {1'b0, d6_q[i], 1'b0} - {2'b00, d6_q[i]});
                end
            end
            OP_COMMIT:
            begin
                for (int i = 0; i < STAGES; i++)
                    s_next[i] = sat32(46'(s_reg[i]) + 46'(d6_sq[i]));
            end
            OP_OUT:
            begin
                if (y_div > 30'sd8388607)
                    out_next = 24'sh7fffff;
                else if (y_div < -30'sd8388608)
                    out_next = 24'sh800000;
                else
                    out_next = y_div[23:0];
            end
            default: ;
        endcase
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
                s_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
                s_reg[i] <= s_next[i];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_reg  <= in_next;
        res_reg <= res_next;
        cut_reg <= cut_next;
        num_reg <= num_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        kh_reg  <= kh_next;
        arg_reg <= arg_next;
        th_reg  <= th_next;
        r_reg   <= r_next;
        out_reg <= out_next;
        for (int i = 0; i < STAGES; i++)
        begin
            t_reg[i]    <= t_next[i];
            d_reg[i]    <= d_next[i];
            acc_reg[i]  <= acc_next[i];
            work_reg[i] <= work_next[i];
            rem3_reg[i] <= rem3_next[i];
            neg_reg[i]  <= neg_next[i];
        end
    end

    assign filter_out = out_reg;

endmodule

// ----- hdl/ota_ladder_filter_rk4_core.sv -----
`timescale 1ns / 1ps
// channel   handshake             payload
// cfg       cfg_wr_en             cfg_index, cfg_data
// in        in_valid / in_ready   audio_in, cutoff_hz, resonance
// out       out_valid / out_ready filter_out
//
// each sample runs the bit-serial gain divider, then per oversample step the shared
// multiplier and tanh unit, 16 ops per rk4 evaluation
// reset clears the four stage states and loads oversample 2, sample rate 44100
// a new sample is taken while the previous result beat waits in the output register
// a stalled output holds the block just before its result write
module ota_ladder_filter_rk4_core
    import olfrk4_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [23:0] audio_in,
    input  logic [15:0]        cutoff_hz,
    input  logic signed [15:0] resonance,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] filter_out
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    olfrk4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // arithmetic and state
    olfrk4_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .audio_in   (audio_in),
        .cutoff_hz  (cutoff_hz),
        .resonance  (resonance),
        .cmd        (cmd),
        .stat       (stat),
        .filter_out (filter_out)
    );

endmodule

// ----- sim/olfrk4_checker.sv -----
`timescale 1ns / 1ps
module olfrk4_checker
    import olfrk4_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [23:0] audio_in,
    input  logic [15:0]        cutoff_hz,
    input  logic signed [15:0] resonance,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [23:0] filter_out,
    output int                 fail_count,
    output int                 pending
);

    typedef longint quad_t [STAGES];

    localparam longint TWO_PI = 64'sd105414268;
    localparam longint GAIN_MAX = 64'sd1 << 28;
    localparam longint K_1P1 = 64'sd72090;
    localparam longint K_1P96 = 64'sd128451;

    longint tanh_tab [0:32];
    logic [OS_W-1:0] os_shadow;
    logic [SR_W-1:0] sr_shadow;
    quad_t stage_q;
    longint drive_in;
    longint fb_gain;
    longint step_gain;
    logic signed [23:0] out_expect_q [$];

    // tanh table, q16, from powers of e^0.25
    initial
    begin
        longint unsigned one;
        longint unsigned p;
        longint unsigned den;
        one = 64'd1 << 20;
        p = one;
        for (int j = 0; j <= 32; j++)
        begin
            den = p + one;
            tanh_tab[j] = longint'((((p - one) << 16) + den / 2) / den);
            p = (p * 64'd1378711793 + (64'd1 << 29)) >> 30;
        end
    end

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint scale_q16(longint a, longint c);
        return (a * c) / 65536;
    endfunction

    // interpolated odd tanh, q26 in and out
    function automatic longint tanh_q26(longint x);
        longint m;
        longint i;
        longint f;
        longint y;
        m = (x < 0) ? -x : x;
        if (m >= (64'sd32 << 23))
            y = tanh_tab[32];
        else
        begin
            i = m >>> 23;
            f = m & ((64'sd1 << 23) - 1);
            y = tanh_tab[i] + ((tanh_tab[i+1] - tanh_tab[i]) * f) / (64'sd1 << 23);
        end
        y = y * 1024;
        return (x < 0) ? -y : y;
    endfunction

    // scaled derivatives of all four stages
    function automatic quad_t ladder_slope(quad_t s);
        quad_t u;
        quad_t dh;
        u[0] = scale_q16(drive_in, K_1P1)
             - (fb_gain * tanh_q26(scale_q16(s[STAGES-1], K_1P96))) / 4096 - s[0];
        for (int i = 1; i < STAGES; i++)
            u[i] = scale_q16(s[i-1], K_1P1) - s[i];
        for (int i = 0; i < STAGES; i++)
            dh[i] = (step_gain * tanh_q26(u[i])) / 16384;
        return dh;
    endfunction

    function automatic void rk4_advance();
        quad_t s;
        quad_t t;
        quad_t d1;
        quad_t d2;
        quad_t d3;
        quad_t d4;
        s = stage_q;
        d1 = ladder_slope(s);
        for (int i = 0; i < STAGES; i++)
            t[i] = clip32(s[i] + d1[i] / 2);
        d2 = ladder_slope(t);
        for (int i = 0; i < STAGES; i++)
            t[i] = clip32(s[i] + d2[i] / 2);
        d3 = ladder_slope(t);
        for (int i = 0; i < STAGES; i++)
            t[i] = clip32(s[i] + d3[i]);
        d4 = ladder_slope(t);
        for (int i = 0; i < STAGES; i++)
            stage_q[i] = clip32(s[i] + (d1[i] + 2 * d2[i] + 2 * d3[i] + d4[i]) / 6);
    endfunction

    // one audio sample through the filter, returns the output sample
    function automatic logic signed [23:0] filter_sample(logic signed [23:0] a,
                                                         logic [15:0] c,
                                                         logic signed [15:0] r);
        longint os;
        longint sr;
        longint g;
        longint y;
        os = longint'(os_shadow);
        sr = longint'(sr_shadow);
        if (os < 1)
            os = 1;
        if (os > MAX_OVERSAMPLE)
            os = MAX_OVERSAMPLE;
        if (sr < 1)
            sr = 1;
        drive_in = longint'(a) * 8;
        fb_gain = (r < 0) ? 0 : longint'(r);
        g = (longint'(c) * TWO_PI) / (os * sr);
        step_gain = (g > GAIN_MAX) ? GAIN_MAX : g;
        for (int j = 0; j < os; j++)
            rk4_advance();
        y = stage_q[STAGES-1] / 8;
        if (y > 64'sd8388607)
            y = 64'sd8388607;
        if (y < -64'sd8388608)
            y = -64'sd8388608;
        return y[23:0];
    endfunction

    assign pending = out_expect_q.size();

    // shadow registers, prediction and comparison
    always @(posedge clk or negedge rst_n)
    begin
        logic signed [23:0] want;
        if (!rst_n)
        begin
            os_shadow <= 4'd2;
            sr_shadow <= 18'd44100;
            for (int i = 0; i < STAGES; i++)
                stage_q[i] = 0;
            out_expect_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (out_expect_q.size() == 0)
                begin
                    $error("filter_out beat with nothing expected: %0d", filter_out);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = out_expect_q.pop_front();
                    if (filter_out !== want)
                    begin
                        $error("filter_out expected %0d actual %0d", want, filter_out);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                out_expect_q.push_back(filter_sample(audio_in, cutoff_hz, resonance));
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_OVERSAMPLE)
                    os_shadow <= cfg_data[OS_W-1:0];
                else if (cfg_index == REG_SAMPLE_RATE)
                    sr_shadow <= cfg_data[SR_W-1:0];
            end
        end
    end

endmodule

// ----- sim/tb_ota_ladder_filter_rk4_core.sv -----
`timescale 1ns / 1ps
module tb_ota_ladder_filter_rk4_core;
    import olfrk4_pkg::*;

    localparam logic [CIDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CIDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 47 + 78 * MAX_OVERSAMPLE + 50;
    localparam int HOLD_CYCLES = 3000;
    localparam int RANDOM_PER_PHASE = 135;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [CIDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [23:0] audio_in;
    logic [15:0]        cutoff_hz;
    logic signed [15:0] resonance;
    logic               out_valid;
    logic               out_ready;
    logic signed [23:0] filter_out;
    int                 fail_count;
    int                 pending;
    int                 phase;
    int                 cycle_count;
    logic               quiet;
    logic               hold_off;

    ota_ladder_filter_rk4_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .audio_in   (audio_in),
        .cutoff_hz  (cutoff_hz),
        .resonance  (resonance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .filter_out (filter_out)
    );

    olfrk4_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .audio_in   (audio_in),
        .cutoff_hz  (cutoff_hz),
        .resonance  (resonance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .filter_out (filter_out),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial
        clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side backpressure
    always @(posedge clk)
        out_ready <= !hold_off && (quiet || ($urandom_range(99) >= 35));

    // long receiver stall so the block fills and stops taking samples
    initial
    begin
        hold_off = 1'b0;
        wait (phase == 3);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // one sample beat, with random gaps ahead of it unless quiet is set
    task automatic send_sample(input logic signed [23:0] a, input logic [15:0] c,
                               input logic signed [15:0] r);
        if (!quiet && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 35)
                @(posedge clk);
        end
        in_valid  <= 1'b1;
        audio_in  <= a;
        cutoff_hz <= c;
        resonance <= r;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // let the last accepted beat be counted, then wait until no result is pending
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_samples(input int n);
        logic signed [23:0] a;
        logic [15:0] c;
        logic signed [15:0] r;
        for (int k = 0; k < n; k++)
        begin
            a = 24'($urandom);
            if ($urandom_range(3) == 0)
                a = a >>> $urandom_range(12);
            c = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(20000, 20));
            case ($urandom_range(3))
                0: r = 16'($urandom);
                1: r = 16'sd0;
                default: r = 16'($urandom_range(4 * 4096));
            endcase
            send_sample(a, c, r);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_OVERSAMPLE;
        cfg_data = '0;
        in_valid = 1'b0;
        audio_in = '0;
        cutoff_hz = '0;
        resonance = '0;
        cycle_count = 0;
        quiet = 1'b0;
        phase = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: field extremes and resonance corners
        send_sample(24'sh7fffff, 16'd1000, 16'sd0);
        send_sample(24'sh7fffff, 16'd1000, 16'sd0);
        send_sample(-24'sd8388608, 16'd65535, 16'sd0);
        send_sample(-24'sd8388608, 16'd0, 16'sd4096);
        send_sample(24'sh7fffff, 16'd65535, 16'sd32767);
        send_sample(24'sd0, 16'd20000, 16'sd32767);
        send_sample(24'sh400000, 16'd5000, -16'sd32768);
        send_sample(24'sh400000, 16'd5000, -16'sd1);
        send_sample(-24'sd1, 16'd1, 16'sd16384);
        send_sample(24'sd1, 16'd30000, 16'sd8192);
        send_sample(24'sh555555, 16'haaaa, 16'sh5555);
        send_sample(24'shaaaaaa, 16'h5555, 16'sh2aaa);
        drain();

        // oversample 1 at a rate of 8000: the step gain saturates
        phase = 1;
        write_reg(REG_OVERSAMPLE, 18'd1);
        write_reg(REG_SAMPLE_RATE, 18'd8000);
        send_sample(24'sh7fffff, 16'd65535, 16'sd32767);
        send_sample(-24'sd8388608, 16'd65535, 16'sd12000);
        random_samples(RANDOM_PER_PHASE);
        drain();

        // most steps at a rate of 192000, no idling
        phase = 2;
        quiet = 1'b1;
        write_reg(REG_OVERSAMPLE, 18'd8);
        write_reg(REG_SAMPLE_RATE, 18'd192000);
        random_samples(RANDOM_PER_PHASE);
        drain();
        quiet = 1'b0;

        // zero registers fall back to one step at 1 hz; spare indexes ignored
        phase = 3;
        write_reg(REG_OVERSAMPLE, 18'd0);
        write_reg(REG_SAMPLE_RATE, 18'd0);
        write_reg(REG_SPARE_2, 18'h3ffff);
        write_reg(REG_SPARE_3, 18'h15555);
        random_samples(RANDOM_PER_PHASE);
        drain();

        // all-ones registers: oversample clamps to the maximum
        phase = 4;
        write_reg(REG_OVERSAMPLE, 18'h3ffff);
        write_reg(REG_SAMPLE_RATE, 18'h3ffff);
        random_samples(RANDOM_PER_PHASE);
        drain();

        phase = 5;
        write_reg(REG_OVERSAMPLE, 18'd4);
        write_reg(REG_SAMPLE_RATE, 18'd48000);
        random_samples(RANDOM_PER_PHASE);
        drain();

        phase = 6;
        write_reg(REG_OVERSAMPLE, 18'd3);
        write_reg(REG_SAMPLE_RATE, 18'd44100);
        random_samples(RANDOM_PER_PHASE);
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/olfrk4_pkg.sv
hdl/olfrk4_ctrl.sv
hdl/olfrk4_dp.sv
hdl/ota_ladder_filter_rk4_core.sv
sim/olfrk4_checker.sv
sim/tb_ota_ladder_filter_rk4_core.sv
